// ===== rtl/bitmap_sort_engine_core_macros.svh =====
// Assertion macros shared by the bitmap sort engine RTL.
`ifndef BITMAP_SORT_ENGINE_CORE_MACROS_SVH
`define BITMAP_SORT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define BSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define BSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bse_pkg.sv =====
// Shared types and constants of the bitmap sort engine.
`timescale 1ns / 1ps
package bse_pkg;

  localparam int unsigned WINDOW_SPAN_DEF = 1048576;
  localparam int unsigned WORD_BITS_DEF   = 64;
  localparam int unsigned BASE_RESET      = 1000000;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned VALUE_W    = 24;
  localparam int unsigned RESULT_W   = 25;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OFF_MAX_W  = 24;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_WINDOW_BASE = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_FETCH  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_NOP    = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REJECT = 3'd2,
    CMD_FETCH  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [OFF_MAX_W-1:0]   offset;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic sweep_last;
  } back_stat_t;

endpackage

// ===== rtl/bse_front.sv =====
// Front end: accepts items and classifies them into back-end commands.
`timescale 1ns / 1ps
module bse_front import bse_pkg::*; #(
  parameter int unsigned WINDOW_SPAN = WINDOW_SPAN_DEF
) (
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic [VALUE_W-1:0]   window_base_i,
  input  logic                 q_full_i,
  input  back_stat_t           stat_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [VALUE_W-1:0] off;
  logic               in_win;

  assign s_ready_o = !q_full_i && !stat_i.init_busy;
  assign push_o    = s_valid_i && s_ready_o;

  assign off    = value_i - window_base_i;
  assign in_win = (value_i >= window_base_i) &&
                  ({1'b0, off} < (VALUE_W + 1)'(WINDOW_SPAN));

  always_comb begin
    cmd_o.offset = OFF_MAX_W'(off);
    unique case (action_e'(action_i))
      ACT_INSERT: cmd_o.kind = in_win ? CMD_INSERT : CMD_REJECT;
      ACT_FETCH:  cmd_o.kind = CMD_FETCH;
      ACT_CLEAR:  cmd_o.kind = CMD_CLEAR;
      default:    cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/bse_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module bse_queue import bse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t               entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     count_q, count_d;

  assign full_o       = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/bse_back.sv =====
// Back end: presence memory, clearing sweep, insert and scan sequencer.
`timescale 1ns / 1ps
module bse_back import bse_pkg::*; #(
  parameter int unsigned WINDOW_SPAN = WINDOW_SPAN_DEF,
  parameter int unsigned WORD_BITS   = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [VALUE_W-1:0]   window_base_i,
  input  logic                 head_valid_i,
  input  cmd_t                 head_i,
  output logic                 pop_o,
  output back_stat_t           stat_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [RESULT_W-1:0]  m_value_o,
  output status_e              m_status_o
);

  localparam int unsigned OW        = $clog2(WINDOW_SPAN);
  localparam int unsigned BW        = $clog2(WORD_BITS);
  localparam int unsigned CW        = OW + 1;
  localparam int unsigned WORD_COUNT = WINDOW_SPAN / WORD_BITS;
  localparam int unsigned AW        = (OW > BW) ? (OW - BW) : 1;
  localparam int unsigned MEM_DEPTH = 2 ** AW;

  typedef enum logic [3:0] {
    S_SWEEP  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_INSERT = 4'b0100,
    S_SCAN   = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         sweep_addr_q, sweep_addr_d;
  logic                  sweep_cmd_q, sweep_cmd_d;
  logic [CW-1:0]         cursor_q, cursor_d;
  logic [AW-1:0]         scan_addr_q, scan_addr_d;
  logic [BW-1:0]         scan_lo_q, scan_lo_d;
  logic [AW-1:0]         ins_addr_q, ins_addr_d;
  logic [BW-1:0]         ins_bit_q, ins_bit_d;
  logic [WORD_BITS-1:0]  rdata_q;
  logic                  out_valid_q, out_valid_d;
  logic [RESULT_W-1:0]   out_value_q, out_value_d;
  status_e               out_status_q, out_status_d;

  logic [WORD_BITS-1:0]  mem [MEM_DEPTH];

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa, mem_ra;
  logic [WORD_BITS-1:0]  mem_wd;

  logic                  emit;
  logic [RESULT_W-1:0]   emit_value;
  status_e               emit_status;

  logic [OW-1:0]         cmd_off;
  logic [OW-1:0]         cur_off;
  logic [WORD_BITS-1:0]  masked;
  logic [BW-1:0]         ffs_idx;
  logic [CW-1:0]         hit_pos;

  assign cmd_off = head_i.offset[OW-1:0];
  assign cur_off = cursor_q[OW-1:0];
  assign masked  = rdata_q & ({WORD_BITS{1'b1}} << scan_lo_q);
  assign hit_pos = (CW'(scan_addr_q) << BW) | CW'(ffs_idx);

  // Lowest set bit of the masked word.
  always_comb begin
    ffs_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        ffs_idx = BW'(i);
      end
    end
  end

  assign pop_o = (state_q == S_IDLE) && head_valid_i && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d      = state_q;
    sweep_addr_d = sweep_addr_q;
    sweep_cmd_d  = sweep_cmd_q;
    cursor_d     = cursor_q;
    scan_addr_d  = scan_addr_q;
    scan_lo_d    = scan_lo_q;
    ins_addr_d   = ins_addr_q;
    ins_bit_d    = ins_bit_q;
    mem_we       = 1'b0;
    mem_wa       = sweep_addr_q;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = AW'(cmd_off >> BW);
    emit         = 1'b0;
    emit_value   = '0;
    emit_status  = ST_OK;

    unique case (state_q)
      S_SWEEP: begin
        mem_we       = 1'b1;
        sweep_addr_d = sweep_addr_q + 1'b1;
        if (sweep_addr_q == AW'(MEM_DEPTH - 1)) begin
          state_d     = S_IDLE;
          sweep_cmd_d = 1'b0;
          emit        = sweep_cmd_q;
        end
      end
      S_IDLE: begin
        if (pop_o) begin
          unique case (head_i.kind)
            CMD_INSERT: begin
              mem_re     = 1'b1;
              ins_addr_d = AW'(cmd_off >> BW);
              ins_bit_d  = cmd_off[BW-1:0];
              state_d    = S_INSERT;
            end
            CMD_REJECT: begin
              emit        = 1'b1;
              emit_status = ST_REJECT;
            end
            CMD_FETCH: begin
              if (cursor_q[OW]) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                mem_re      = 1'b1;
                mem_ra      = AW'(cur_off >> BW);
                scan_addr_d = AW'(cur_off >> BW);
                scan_lo_d   = cur_off[BW-1:0];
                state_d     = S_SCAN;
              end
            end
            CMD_CLEAR: begin
              cursor_d     = '0;
              sweep_addr_d = '0;
              sweep_cmd_d  = 1'b1;
              state_d      = S_SWEEP;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_INSERT: begin
        mem_we  = 1'b1;
        mem_wa  = ins_addr_q;
        mem_wd  = rdata_q | (WORD_BITS'(1) << ins_bit_q);
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (masked != '0) begin
          cursor_d   = hit_pos + 1'b1;
          emit       = 1'b1;
          emit_value = {1'b0, window_base_i} + RESULT_W'(hit_pos);
          state_d    = S_IDLE;
        end else if (scan_addr_q == AW'(WORD_COUNT - 1)) begin
          cursor_d    = CW'(WINDOW_SPAN);
          emit        = 1'b1;
          emit_status = ST_EMPTY;
          state_d     = S_IDLE;
        end else begin
          mem_re      = 1'b1;
          mem_ra      = scan_addr_q + 1'b1;
          scan_addr_d = scan_addr_q + 1'b1;
          scan_lo_d   = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output slot: load on a result, drop once taken.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_value_d  = emit_value;
      out_status_d = emit_status;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      sweep_addr_q <= '0;
      sweep_cmd_q  <= 1'b0;
      cursor_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_cmd_q  <= sweep_cmd_d;
      cursor_q     <= cursor_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q  <= scan_addr_d;
    scan_lo_q    <= scan_lo_d;
    ins_addr_q   <= ins_addr_d;
    ins_bit_q    <= ins_bit_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  assign stat_o.init_busy  = (state_q == S_SWEEP) && !sweep_cmd_q;
  assign stat_o.sweep_last = (sweep_addr_q == AW'(MEM_DEPTH - 1));

  assign m_valid_o  = out_valid_q;
  assign m_value_o  = out_value_q;
  assign m_status_o = out_status_q;

endmodule

// ===== rtl/bitmap_sort_engine_core.sv =====
// An insert reads its bitmap word and writes it back with the bit set; a fetch reads
//   words from the cursor on until one holds a set bit or the last word has been read.
// The back end finishes each command before it takes the next; a clear sweeps all
//   2**(log2(WINDOW_SPAN) - log2(WORD_BITS)) words (16384 at default sizes), one word per cycle.
// Reset: asynchronous, active low; base returns to 1000000, cursor to zero, and a
//   zeroing sweep of the whole store runs with s_axis_tready low before the first item.
`timescale 1ns / 1ps
`include "bitmap_sort_engine_core_macros.svh"
module bitmap_sort_engine_core import bse_pkg::*; #(
  parameter int unsigned WINDOW_SPAN = WINDOW_SPAN_DEF,
  parameter int unsigned WORD_BITS   = WORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VALUE_W-1:0]     s_axis_tdata,   // [23:0] value
  input  logic [ACTION_W-1:0]    s_axis_tuser,   // [1:0] action
  // Result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata,   // [24:0] sorted_value, rest zero
  output logic [STATUS_W-1:0]    m_axis_tuser,   // [1:0] status
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // Window base register: bit zero of the store stands for this value.
  logic [VALUE_W-1:0] window_base_q;
  logic               cfg_wr;

  // Front to queue to back.
  cmd_t               front_cmd;
  logic               front_push;
  logic               q_full;
  logic               q_head_valid;
  cmd_t               q_head;
  logic               back_pop;
  back_stat_t         stat;

  logic [RESULT_W-1:0] res_value;
  status_e             res_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_BASE);

  // Register reads come straight off the address; only the window base exists.
  assign prdata = (paddr[2] == REG_WINDOW_BASE) ? APB_DATA_W'(window_base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_base_q <= VALUE_W'(BASE_RESET);
    end else if (cfg_wr) begin
      window_base_q <= pwdata[VALUE_W-1:0];
    end
  end

  // Classify each item: in-window check and offset for inserts, plain codes otherwise.
  bse_front #(
    .WINDOW_SPAN (WINDOW_SPAN)
  ) u_front (
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .action_i      (s_axis_tuser),
    .value_i       (s_axis_tdata),
    .window_base_i (window_base_q),
    .q_full_i      (q_full),
    .stat_i        (stat),
    .push_o        (front_push),
    .cmd_o         (front_cmd)
  );

  // Hold classified commands while the back end walks words or sweeps.
  bse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_push),
    .cmd_i        (front_cmd),
    .full_o       (q_full),
    .pop_i        (back_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  // Carry out commands against the presence store and drive the result slot.
  bse_back #(
    .WINDOW_SPAN (WINDOW_SPAN),
    .WORD_BITS   (WORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_base_i (window_base_q),
    .head_valid_i  (q_head_valid),
    .head_i        (q_head),
    .pop_o         (back_pop),
    .stat_o        (stat),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_value_o     (res_value),
    .m_status_o    (res_status)
  );

  assign m_axis_tdata = 32'(res_value);
  assign m_axis_tuser = res_status;

  // No item enters and no result leaves during the post-reset sweep.
  `BSE_ASSERT_IMPL(a_sweep_blocks_io, stat.init_busy, !s_axis_tready && !m_axis_tvalid, "item moved during reset sweep")
  // Rejects and exhausted fetches carry a zero value.
  `BSE_ASSERT_IMPL(a_fail_zero_value, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "nonzero value on failed result")
  // The post-reset sweep runs to its last word without a break.
  `BSE_ASSERT_NEXT(a_sweep_continues, stat.init_busy && !stat.sweep_last, stat.init_busy, "reset sweep ended early")

endmodule
